>>> rtl/eyq_pkg.sv
package eyq_pkg;

  localparam int CW   = 34;
  localparam int MW   = 32;
  localparam int FRAC = 30;

  localparam logic signed [CW-1:0] PI_FX      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_FX = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_FX    = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cs_t;

  function automatic logic signed [CW-1:0] atan_val(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // product of two 30 fraction bit values, rounded back to 30 fraction bits
  function automatic logic signed [MW-1:0] mul2(input logic signed [MW-1:0] a,
                                                input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    logic signed [2*MW-1:0] r;
    p = a * b;
    r = (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return r[MW-1:0];
  endfunction

endpackage

>>> rtl/eyq_prerotate.sv
module eyq_prerotate #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output eyq_pkg::cs_t                 q
);

  logic signed [eyq_pkg::CW-1:0] za;
  logic signed [eyq_pkg::CW-1:0] zf;
  eyq_pkg::cs_t                  q_nxt;
  eyq_pkg::cs_t                  q_r;

  // half angle with 30 fraction bits
  assign za = eyq_pkg::CW'(angle);
  assign zf = za <<< (33 - ANGLE_BITS);

  always_comb begin
    q_nxt.x   = eyq_pkg::GAIN_FX;
    q_nxt.y   = '0;
    q_nxt.z   = zf;
    q_nxt.neg = 1'b0;
    if (zf > eyq_pkg::HALF_PI_FX) begin
      q_nxt.z   = zf - eyq_pkg::PI_FX;
      q_nxt.neg = 1'b1;
    end else if (zf < -eyq_pkg::HALF_PI_FX) begin
      q_nxt.z   = zf + eyq_pkg::PI_FX;
      q_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/eyq_cordic_stage.sv
module eyq_cordic_stage #(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         en,
  input  eyq_pkg::cs_t d,
  output eyq_pkg::cs_t q
);

  logic signed [eyq_pkg::CW-1:0] dx;
  logic signed [eyq_pkg::CW-1:0] dy;
  eyq_pkg::cs_t                  q_nxt;
  eyq_pkg::cs_t                  q_r;

  assign dx = d.y >>> STAGE;
  assign dy = d.x >>> STAGE;

  always_comb begin
    q_nxt.neg = d.neg;
    if (!d.z[eyq_pkg::CW-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - eyq_pkg::atan_val(STAGE);
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + eyq_pkg::atan_val(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/eyq_quat_mul.sv
module eyq_quat_mul #(
  parameter int QUAT_BITS = 16
) (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  eyq_pkg::cs_t                yaw,
  input  eyq_pkg::cs_t                pitch,
  input  eyq_pkg::cs_t                roll,
  output logic signed [QUAT_BITS-1:0] quat_x,
  output logic signed [QUAT_BITS-1:0] quat_y,
  output logic signed [QUAT_BITS-1:0] quat_z,
  output logic signed [QUAT_BITS-1:0] quat_w
);

  localparam int SH = eyq_pkg::FRAC - (QUAT_BITS - 2);
  localparam int MW = eyq_pkg::MW;
  localparam int CW = eyq_pkg::CW;

  logic signed [MW-1:0] cy, sy, cp, sp, cr, sr;
  logic signed [MW-1:0] cysp_r, sycp_r, cycp_r, sysp_r, cr_r, sr_r;
  logic signed [MW-1:0] t_r [0:7];
  logic signed [QUAT_BITS-1:0] qx_r, qy_r, qz_r, qw_r;

  function automatic logic signed [MW-1:0] sel(input logic signed [CW-1:0] v,
                                               input logic neg);
    logic signed [CW-1:0] r;
    r = neg ? -v : v;
    return r[MW-1:0];
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] to_out(input logic signed [MW-1:0] a,
                                                         input logic signed [MW-1:0] b,
                                                         input logic sub);
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] rnd;
    logic signed [CW-1:0] one;
    logic signed [CW-1:0] r;
    v   = sub ? (CW'(a) - CW'(b)) : (CW'(a) + CW'(b));
    rnd = (34'sd1 <<< SH) >>> 1;
    one = 34'sd1 <<< (QUAT_BITS - 2);
    r   = (v + rnd) >>> SH;
    if (r > one) begin
      r = one;
    end else if (r < -one) begin
      r = -one;
    end
    return r[QUAT_BITS-1:0];
  endfunction

  assign cy = sel(yaw.x, yaw.neg);
  assign sy = sel(yaw.y, yaw.neg);
  assign cp = sel(pitch.x, pitch.neg);
  assign sp = sel(pitch.y, pitch.neg);
  assign cr = sel(roll.x, roll.neg);
  assign sr = sel(roll.y, roll.neg);

  // pair products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cysp_r <= eyq_pkg::mul2(cy, sp);
      sycp_r <= eyq_pkg::mul2(sy, cp);
      cycp_r <= eyq_pkg::mul2(cy, cp);
      sysp_r <= eyq_pkg::mul2(sy, sp);
      cr_r   <= cr;
      sr_r   <= sr;
    end
  end

  // triple products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r[0] <= eyq_pkg::mul2(cysp_r, cr_r);
      t_r[1] <= eyq_pkg::mul2(sycp_r, sr_r);
      t_r[2] <= eyq_pkg::mul2(sycp_r, cr_r);
      t_r[3] <= eyq_pkg::mul2(cysp_r, sr_r);
      t_r[4] <= eyq_pkg::mul2(cycp_r, sr_r);
      t_r[5] <= eyq_pkg::mul2(sysp_r, cr_r);
      t_r[6] <= eyq_pkg::mul2(cycp_r, cr_r);
      t_r[7] <= eyq_pkg::mul2(sysp_r, sr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      qx_r <= to_out(t_r[0], t_r[1], 1'b0);
      qy_r <= to_out(t_r[2], t_r[3], 1'b1);
      qz_r <= to_out(t_r[4], t_r[5], 1'b1);
      qw_r <= to_out(t_r[6], t_r[7], 1'b0);
    end
  end

  assign quat_x = qx_r;
  assign quat_y = qy_r;
  assign quat_z = qz_r;
  assign quat_w = qw_r;

endmodule

>>> rtl/euler_yxz_to_quaternion_unit.sv
// euler angles (yaw about y, pitch about x, roll about z) to unit quaternion, y-x-z order
// input channel: in_valid with in_yaw_angle, in_pitch_angle, in_roll_angle as signed
// q4.(ANGLE_BITS-4) radians; a word is taken on a clock edge with in_valid high and
// in_stall low
// output channel: out_valid with out_quat_x/y/z/w as signed q2.(QUAT_BITS-2), saturated
// to plus or minus one; a word leaves on an edge with out_valid high and out_stall low
// the pipeline has one range-reduction stage, one stage per cordic iteration,
// then three stages for the pair products, triple products and final rounding
// with saturation
// throughput is one word per cycle while out_stall is low; every stage holds its own valid bit, so a stage
// loads whenever it is empty or the stage after it moves on
// when the receiver stalls the output word holds and the stages behind it keep
// filling any gaps; in_stall rises only once every stage is occupied
// reset empties the pipeline; no word is in flight after it and nothing is stored
// between words
module euler_yxz_to_quaternion_unit #(
  parameter int ANGLE_BITS    = 16,
  parameter int QUAT_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  input  logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] in_roll_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [QUAT_BITS-1:0]  out_quat_x,
  output logic signed [QUAT_BITS-1:0]  out_quat_y,
  output logic signed [QUAT_BITS-1:0]  out_quat_z,
  output logic signed [QUAT_BITS-1:0]  out_quat_w
);

  localparam int NSTG = CORDIC_STAGES + 4;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] en;

  eyq_pkg::cs_t yaw_c   [0:CORDIC_STAGES];
  eyq_pkg::cs_t pitch_c [0:CORDIC_STAGES];
  eyq_pkg::cs_t roll_c  [0:CORDIC_STAGES];

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];

  eyq_prerotate #(.ANGLE_BITS(ANGLE_BITS)) u_pre_yaw (
    .clk(clk), .en(en[0]), .angle(in_yaw_angle), .q(yaw_c[0])
  );
  eyq_prerotate #(.ANGLE_BITS(ANGLE_BITS)) u_pre_pitch (
    .clk(clk), .en(en[0]), .angle(in_pitch_angle), .q(pitch_c[0])
  );
  eyq_prerotate #(.ANGLE_BITS(ANGLE_BITS)) u_pre_roll (
    .clk(clk), .en(en[0]), .angle(in_roll_angle), .q(roll_c[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    eyq_cordic_stage #(.STAGE(i)) u_yaw (
      .clk(clk), .en(en[i+1]), .d(yaw_c[i]), .q(yaw_c[i+1])
    );
    eyq_cordic_stage #(.STAGE(i)) u_pitch (
      .clk(clk), .en(en[i+1]), .d(pitch_c[i]), .q(pitch_c[i+1])
    );
    eyq_cordic_stage #(.STAGE(i)) u_roll (
      .clk(clk), .en(en[i+1]), .d(roll_c[i]), .q(roll_c[i+1])
    );
  end

  eyq_quat_mul #(.QUAT_BITS(QUAT_BITS)) u_mul (
    .clk    (clk),
    .en     (en[NSTG-1:NSTG-3]),
    .yaw    (yaw_c[CORDIC_STAGES]),
    .pitch  (pitch_c[CORDIC_STAGES]),
    .roll   (roll_c[CORDIC_STAGES]),
    .quat_x (out_quat_x),
    .quat_y (out_quat_y),
    .quat_z (out_quat_z),
    .quat_w (out_quat_w)
  );

  localparam logic signed [QUAT_BITS-1:0] QONE = QUAT_BITS'(1) <<< (QUAT_BITS - 2);

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_x <= QONE && out_quat_x >= -QONE &&
                   out_quat_y <= QONE && out_quat_y >= -QONE &&
                   out_quat_z <= QONE && out_quat_z >= -QONE &&
                   out_quat_w <= QONE && out_quat_w >= -QONE))
    else $error("quaternion component outside plus or minus one");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word present after reset");

endmodule
